@@ rtl/ucr_pkg.sv @@
`timescale 1ns / 1ps
package ucr_pkg;

  localparam int RING_DEPTH_DEF = 64;

  localparam logic [1:0] CMD_RX    = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_ARM   = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [1:0] REG_ACK    = 2'd0;
  localparam logic [1:0] REG_NACK   = 2'd1;
  localparam logic [1:0] REG_ESCAPE = 2'd2;

  localparam logic [7:0] ACK_RESET    = 8'h06;
  localparam logic [7:0] NACK_RESET   = 8'h15;
  localparam logic [7:0] ESCAPE_RESET = 8'h1B;
  localparam logic [7:0] GLOBAL_ESC   = 8'h1B;
  localparam logic [7:0] ANGLE_RESET  = 8'd90;
  localparam logic [7:0] ANGLE_MAX    = 8'd180;
  localparam logic [7:0] CHAR_R       = 8'h52;
  localparam logic [7:0] CHAR_G       = 8'h47;
  localparam logic [7:0] CHAR_0       = 8'h30;
  localparam logic [7:0] CHAR_2       = 8'h32;
  localparam logic [7:0] CHAR_6       = 8'h36;

  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_MEAS1 = 3'd1;
  localparam logic [2:0] MODE_ANGLE = 3'd2;
  localparam logic [2:0] MODE_MEAS4 = 3'd4;
  localparam logic [2:0] MODE_FILE  = 3'd5;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] rx_byte;
  } ucr_in_t;

  typedef struct packed {
    logic       pop_valid;
    logic [7:0] pop_byte;
    logic [2:0] mode;
    logic [7:0] angle;
    logic       angle_wait;
    logic       go_flag;
    logic       ack_captured;
    logic [7:0] ack_byte_seen;
    logic       cancel_flag;
    logic       overflow_flag;
    logic       has_data;
    logic       file_mode;
  } ucr_out_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] angle;
    logic       angle_wait;
    logic       go_flag;
    logic       ack_captured;
    logic [7:0] ack_byte_seen;
    logic       cancel_flag;
    logic       overflow_flag;
    logic       has_data;
    logic       file_mode;
  } ucr_status_t;

endpackage

@@ rtl/ucr_in_if.sv @@
`timescale 1ns / 1ps
interface ucr_in_if import ucr_pkg::*; ();
  logic    valid;
  logic    ready;
  ucr_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/ucr_out_if.sv @@
`timescale 1ns / 1ps
interface ucr_out_if import ucr_pkg::*; ();
  logic     valid;
  logic     ready;
  ucr_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/ucr_cfg_if.sv @@
`timescale 1ns / 1ps
interface ucr_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/ucr_ram.sv @@
`timescale 1ns / 1ps
module ucr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/ucr_decode.sv @@
`timescale 1ns / 1ps
module ucr_decode import ucr_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  localparam int PtrW = $clog2(RING_DEPTH)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  ucr_in_t         item,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_idx,
  input  logic [7:0]      cfg_wdata,
  output ucr_status_t     status,
  output logic            pop_hit,
  output logic            ram_we,
  output logic [PtrW-1:0] ram_waddr,
  output logic [7:0]      ram_wdata,
  output logic            ram_re,
  output logic [PtrW-1:0] ram_raddr
);

  localparam logic [PtrW-1:0] PtrLast = PtrW'(RING_DEPTH - 1);

  logic [7:0]      ack_code_r, nack_code_r, esc_code_r;
  logic [2:0]      mode_r, mode_nxt;
  logic [7:0]      angle_r, angle_nxt;
  logic            angle_pend_r, angle_pend_nxt;
  logic            go_r, go_nxt;
  logic            ack_flag_r, ack_flag_nxt;
  logic [7:0]      ack_val_r, ack_val_nxt;
  logic            cancel_r, cancel_nxt;
  logic            ovf_r, ovf_nxt;
  logic            data_r, data_nxt;
  logic            armed_r, armed_nxt;
  logic [PtrW-1:0] wptr_r, wptr_nxt;
  logic [PtrW-1:0] rptr_r, rptr_nxt;
  logic [PtrW-1:0] wptr_inc, rptr_inc;
  logic [7:0]      rx;
  logic            meas;
  logic            push;
  logic            pop;

  assign wptr_inc = (wptr_r == PtrLast) ? '0 : wptr_r + 1'b1;
  assign rptr_inc = (rptr_r == PtrLast) ? '0 : rptr_r + 1'b1;
  assign rx       = item.rx_byte;
  assign meas     = (mode_r >= MODE_MEAS1) && (mode_r <= MODE_MEAS4);

  always_comb begin
    mode_nxt       = mode_r;
    angle_nxt      = angle_r;
    angle_pend_nxt = angle_pend_r;
    go_nxt         = go_r;
    ack_flag_nxt   = ack_flag_r;
    ack_val_nxt    = ack_val_r;
    cancel_nxt     = cancel_r;
    ovf_nxt        = ovf_r;
    data_nxt       = data_r;
    armed_nxt      = armed_r;
    wptr_nxt       = wptr_r;
    rptr_nxt       = rptr_r;
    push           = 1'b0;
    pop            = 1'b0;
    unique case (item.cmd)
      CMD_RX: begin
        priority if (meas && (rx == ack_code_r || rx == nack_code_r)) begin
          ack_val_nxt  = rx;
          ack_flag_nxt = 1'b1;
        end else if (rx == GLOBAL_ESC) begin
          armed_nxt      = 1'b0;
          cancel_nxt     = 1'b1;
          wptr_nxt       = '0;
          rptr_nxt       = '0;
          data_nxt       = 1'b0;
          ovf_nxt        = 1'b0;
          angle_pend_nxt = 1'b0;
          go_nxt         = 1'b0;
          mode_nxt       = MODE_IDLE;
        end else if (mode_r == MODE_ANGLE && !angle_pend_r && rx <= ANGLE_MAX) begin
          angle_nxt = rx;
        end else if (mode_r == MODE_FILE && !armed_r && rx == CHAR_R) begin
          wptr_nxt  = '0;
          rptr_nxt  = '0;
          data_nxt  = 1'b0;
          ovf_nxt   = 1'b0;
          armed_nxt = 1'b1;
        end else if (mode_r == MODE_FILE && armed_r && rx == esc_code_r) begin
          armed_nxt  = 1'b0;
          cancel_nxt = 1'b1;
          wptr_nxt   = '0;
          rptr_nxt   = '0;
          data_nxt   = 1'b0;
        end else if (mode_r == MODE_FILE && armed_r) begin
          if (wptr_inc != rptr_r) begin
            push     = 1'b1;
            wptr_nxt = wptr_inc;
          end else begin
            ovf_nxt = 1'b1;
          end
          data_nxt = 1'b1;
        end else if (angle_pend_r) begin
          angle_nxt      = rx;
          angle_pend_nxt = 1'b0;
        end else if (rx >= CHAR_0 && rx <= CHAR_6) begin
          mode_nxt = 3'(rx - CHAR_0);
          if (rx == CHAR_2) begin
            angle_pend_nxt = 1'b1;
          end
        end else if (rx == CHAR_G) begin
          go_nxt = 1'b1;
        end else begin
          go_nxt = go_r;
        end
      end
      CMD_POP: begin
        if (wptr_r != rptr_r) begin
          pop      = 1'b1;
          rptr_nxt = rptr_inc;
          if (wptr_r == rptr_inc) begin
            data_nxt = 1'b0;
          end
        end
      end
      CMD_ARM: begin
        wptr_nxt   = '0;
        rptr_nxt   = '0;
        data_nxt   = 1'b0;
        ovf_nxt    = 1'b0;
        cancel_nxt = 1'b0;
        armed_nxt  = 1'b1;
      end
      CMD_CLEAR: begin
        go_nxt       = 1'b0;
        cancel_nxt   = 1'b0;
        ack_flag_nxt = 1'b0;
      end
      default: begin
        go_nxt = go_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_code_r   <= ACK_RESET;
      nack_code_r  <= NACK_RESET;
      esc_code_r   <= ESCAPE_RESET;
      mode_r       <= MODE_IDLE;
      angle_r      <= ANGLE_RESET;
      angle_pend_r <= 1'b0;
      go_r         <= 1'b0;
      ack_flag_r   <= 1'b0;
      ack_val_r    <= '0;
      cancel_r     <= 1'b0;
      ovf_r        <= 1'b0;
      data_r       <= 1'b0;
      armed_r      <= 1'b0;
      wptr_r       <= '0;
      rptr_r       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_ACK:    ack_code_r  <= cfg_wdata;
          REG_NACK:   nack_code_r <= cfg_wdata;
          REG_ESCAPE: esc_code_r  <= cfg_wdata;
          default:    ack_code_r  <= ack_code_r;
        endcase
      end
      if (accept) begin
        mode_r       <= mode_nxt;
        angle_r      <= angle_nxt;
        angle_pend_r <= angle_pend_nxt;
        go_r         <= go_nxt;
        ack_flag_r   <= ack_flag_nxt;
        ack_val_r    <= ack_val_nxt;
        cancel_r     <= cancel_nxt;
        ovf_r        <= ovf_nxt;
        data_r       <= data_nxt;
        armed_r      <= armed_nxt;
        wptr_r       <= wptr_nxt;
        rptr_r       <= rptr_nxt;
      end
    end
  end

  always_comb begin
    status.mode          = mode_nxt;
    status.angle         = angle_nxt;
    status.angle_wait    = angle_pend_nxt;
    status.go_flag       = go_nxt;
    status.ack_captured  = ack_flag_nxt;
    status.ack_byte_seen = ack_val_nxt;
    status.cancel_flag   = cancel_nxt;
    status.overflow_flag = ovf_nxt;
    status.has_data      = data_nxt;
    status.file_mode     = armed_nxt;
  end

  assign pop_hit   = pop;
  assign ram_we    = accept && push;
  assign ram_waddr = wptr_r;
  assign ram_wdata = rx;
  assign ram_re    = accept && pop;
  assign ram_raddr = rptr_r;

endmodule

@@ rtl/uart_command_receiver_core.sv @@
`timescale 1ns / 1ps
// Decodes received serial bytes and the pop, arm and clear commands, and returns one
// status transfer for every input transfer, showing the state after that item. A new
// item is taken every cycle unless the output stalls. Results pass through the staging
// and output registers, as the ring buffer memory has a registered read; the output
// register lets input continue while a result waits. The ring holds RING_DEPTH - 1
// bytes. Config writes are taken at any time but are meant for when the block is idle.
module uart_command_receiver_core import ucr_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  ucr_in_if.sink    in_ch,
  ucr_out_if.source out_ch,
  ucr_cfg_if.sink   cfg_ch
);

  localparam int PtrW = $clog2(RING_DEPTH);

  logic            accept;
  ucr_status_t     status;
  logic            pop_hit;
  logic            ram_we, ram_re;
  logic [PtrW-1:0] ram_waddr, ram_raddr;
  logic [7:0]      ram_wdata, ram_rdata;
  logic            stg_valid_r;
  ucr_status_t     stg_stat_r;
  logic            stg_pop_r;
  logic            stg_move;
  logic            out_valid_r;
  ucr_out_t        out_data_r, out_data_nxt;

  assign stg_move     = stg_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !stg_valid_r || stg_move;
  assign accept       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  ucr_decode #(
    .RING_DEPTH (RING_DEPTH)
  ) u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (in_ch.data),
    .cfg_we    (cfg_ch.valid),
    .cfg_idx   (cfg_ch.index),
    .cfg_wdata (cfg_ch.data),
    .status    (status),
    .pop_hit   (pop_hit),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr)
  );

  ucr_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    out_data_nxt.pop_valid     = stg_pop_r;
    out_data_nxt.pop_byte      = stg_pop_r ? ram_rdata : 8'd0;
    out_data_nxt.mode          = stg_stat_r.mode;
    out_data_nxt.angle         = stg_stat_r.angle;
    out_data_nxt.angle_wait    = stg_stat_r.angle_wait;
    out_data_nxt.go_flag       = stg_stat_r.go_flag;
    out_data_nxt.ack_captured  = stg_stat_r.ack_captured;
    out_data_nxt.ack_byte_seen = stg_stat_r.ack_byte_seen;
    out_data_nxt.cancel_flag   = stg_stat_r.cancel_flag;
    out_data_nxt.overflow_flag = stg_stat_r.overflow_flag;
    out_data_nxt.has_data      = stg_stat_r.has_data;
    out_data_nxt.file_mode     = stg_stat_r.file_mode;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        stg_valid_r <= 1'b1;
      end else if (stg_move) begin
        stg_valid_r <= 1'b0;
      end
      if (stg_move) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_stat_r <= status;
      stg_pop_r  <= pop_hit;
    end
    if (stg_move) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule
